// File: rtl/pnh_pkg.sv
// Shared types and constants of the pixel neighbourhood hash block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package pnh_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned PROD_W  = 2 * PIX_W;
  localparam int unsigned SUM_W   = 3 * PIX_W;
  localparam int unsigned CNT_W   = $clog2(SUM_W);

  localparam logic [PIX_W-1:0] BASE_WEIGHT_RST  = PIX_W'(8);
  localparam logic [PIX_W-1:0] MODULUS_RST      = PIX_W'(7);
  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = DIM_W'(1024);

  typedef enum logic [IDX_W-1:0] {
    CFG_BASE_WEIGHT  = 2'd0,
    CFG_MODULUS      = 2'd1,
    CFG_FRAME_WIDTH  = 2'd2,
    CFG_FRAME_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD_A  = 9'b000000010,
    S_RD_B  = 9'b000000100,
    S_MUL1  = 9'b000001000,
    S_MUL2  = 9'b000010000,
    S_SUM   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_EMIT1 = 9'b010000000,
    S_EMIT2 = 9'b100000000
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_right;
    logic latch_above;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_step;
    logic load_main;
    logic load_tail;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic has_main;
    logic last_row;
    logic single;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: rtl/pixel_neighbourhood_hash.sv
// Neighbourhood hash over a raster stream of 8-bit grey pixels, top level.
// Instantiates pnh_ctrl and pnh_datapath; takes types from pnh_pkg.
//
// Each accepted pixel word p(i+1,j) completes the hash of output pixel (i,j),
// (w*p(i,j) + w*w*p(i+1,j) + p(i,j+1)) mod m, using the previous row held in a
// 1024-entry line store; the last column yields zero, row 0 yields nothing,
// and each pixel of the last row adds a zero word for its own position.
// Between acceptance and the next acceptance a pixel runs through two store
// reads, two multiply stages, one add and the bit-serial remainder unit, and
// then, if it yields a word, waits until the result side is ready. A result
// word waits in an output register, so the next pixel is accepted while it
// is still pending. The line store is not cleared after reset; entries are
// written before data read from them is used. Configuration writes (index 0
// base weight, 1 modulus, 2 frame width, 3 frame height) are always taken; the
// user must write them only while the block is idle; the block does not check.
`default_nettype none

module pixel_neighbourhood_hash (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic [pnh_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [pnh_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [pnh_pkg::PIX_W-1:0] pixel_i,
  input  wire logic                      frame_start_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [pnh_pkg::PIX_W-1:0] code_o,
  output      logic [pnh_pkg::POS_W-1:0] out_row_o,
  output      logic [pnh_pkg::POS_W-1:0] out_col_o,
  output      logic                      last_of_run_o
);

  pnh_pkg::ctrl_cmd_t cmd;
  pnh_pkg::ctrl_sts_t sts;

  // Registers are plain flops with no side effects, so writes never stall.
  assign cfg_ready_o = 1'b1;

  pnh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pnh_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .code_o        (code_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .last_of_run_o (last_of_run_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

`default_nettype wire

// File: rtl/pnh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pnh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/pnh_ctrl.sv
// Sequencing state machine of the neighbourhood hash: one pixel at a time.
// Depends on pnh_pkg for the state, command and status types.
`default_nettype none

module pnh_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire pnh_pkg::ctrl_sts_t sts_i,
  output      pnh_pkg::ctrl_cmd_t cmd_o
);

  pnh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pnh_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pnh_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = pnh_pkg::S_RD_A;
        end
      end
      pnh_pkg::S_RD_A: begin
        state_d = pnh_pkg::S_RD_B;
      end
      pnh_pkg::S_RD_B: begin
        cmd_o.rd_right    = 1'b1;
        cmd_o.latch_above = 1'b1;
        state_d           = pnh_pkg::S_MUL1;
      end
      pnh_pkg::S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = pnh_pkg::S_MUL2;
      end
      pnh_pkg::S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = pnh_pkg::S_SUM;
      end
      pnh_pkg::S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = pnh_pkg::S_DIV;
      end
      pnh_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = pnh_pkg::S_EMIT1;
        end
      end
      pnh_pkg::S_EMIT1: begin
        if (sts_i.has_main) begin
          if (sts_i.out_free) begin
            cmd_o.load_main = 1'b1;
            state_d = sts_i.last_row ? pnh_pkg::S_EMIT2 : pnh_pkg::S_IDLE;
          end
        end else if (sts_i.single) begin
          if (sts_i.out_free) begin
            cmd_o.load_tail = 1'b1;
            state_d         = pnh_pkg::S_IDLE;
          end
        end else begin
          state_d = pnh_pkg::S_IDLE;
        end
      end
      pnh_pkg::S_EMIT2: begin
        if (sts_i.out_free) begin
          cmd_o.load_tail = 1'b1;
          state_d         = pnh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pnh_pkg::S_IDLE;
      end
    endcase
  end

  // The second word of a pixel exists only for a last-row pixel with a row above.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pnh_pkg::S_EMIT2) |-> (sts_i.has_main && sts_i.last_row))
    else $error("second result state entered without a last-row pixel");

  // A word is never loaded over one the consumer has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_main || cmd_o.load_tail) |-> sts_i.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

// File: rtl/pnh_datapath.sv
// Datapath of the neighbourhood hash: registers, position, line store,
// products, bit-serial remainder and output register. Depends on pnh_pkg, pnh_ram.
`default_nettype none

module pnh_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [pnh_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [pnh_pkg::CFG_W-1:0]   cfg_data_i,
  input  wire logic [pnh_pkg::PIX_W-1:0]   pixel_i,
  input  wire logic                        frame_start_i,
  input  wire logic                        out_ready_i,
  output      logic                        out_valid_o,
  output      logic [pnh_pkg::PIX_W-1:0]   code_o,
  output      logic [pnh_pkg::POS_W-1:0]   out_row_o,
  output      logic [pnh_pkg::POS_W-1:0]   out_col_o,
  output      logic                        last_of_run_o,
  input  wire pnh_pkg::ctrl_cmd_t          cmd_i,
  output      pnh_pkg::ctrl_sts_t          sts_o
);

  localparam int unsigned PW = pnh_pkg::PIX_W;
  localparam int unsigned QW = pnh_pkg::POS_W;
  localparam int unsigned DW = pnh_pkg::DIM_W;
  localparam int unsigned SW = pnh_pkg::SUM_W;
  localparam int unsigned MW = pnh_pkg::PROD_W;
  localparam int unsigned NW = pnh_pkg::CNT_W;

  // Configuration registers.
  logic [PW-1:0] weight_q, modulus_q;
  logic [DW-1:0] fwidth_q, fheight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q  <= pnh_pkg::BASE_WEIGHT_RST;
      modulus_q <= pnh_pkg::MODULUS_RST;
      fwidth_q  <= pnh_pkg::FRAME_WIDTH_RST;
      fheight_q <= pnh_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (pnh_pkg::cfg_idx_e'(cfg_index_i))
        pnh_pkg::CFG_BASE_WEIGHT:  weight_q  <= cfg_data_i[PW-1:0];
        pnh_pkg::CFG_MODULUS:      modulus_q <= cfg_data_i[PW-1:0];
        pnh_pkg::CFG_FRAME_WIDTH:  fwidth_q  <= cfg_data_i[DW-1:0];
        pnh_pkg::CFG_FRAME_HEIGHT: fheight_q <= cfg_data_i[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective frame size: zero counts as one, oversize saturates.
  logic [DW-1:0] wdt, hgt;
  always_comb begin
    if (fwidth_q == '0) begin
      wdt = DW'(1);
    end else if (fwidth_q > DW'(pnh_pkg::MAX_WIDTH)) begin
      wdt = DW'(pnh_pkg::MAX_WIDTH);
    end else begin
      wdt = fwidth_q;
    end
    if (fheight_q == '0) begin
      hgt = DW'(1);
    end else if (fheight_q > DW'(pnh_pkg::MAX_HEIGHT)) begin
      hgt = DW'(pnh_pkg::MAX_HEIGHT);
    end else begin
      hgt = fheight_q;
    end
  end

  // Raster position of the next pixel.
  logic [QW-1:0] row_q, col_q;
  logic [QW-1:0] r_cur, c_cur;
  logic [DW-1:0] r_inc, c_inc;
  logic          wrap;

  assign wrap  = frame_start_i || ({1'b0, col_q} >= wdt) || ({1'b0, row_q} >= hgt);
  assign r_cur = wrap ? '0 : row_q;
  assign c_cur = wrap ? '0 : col_q;
  assign r_inc = {1'b0, r_cur} + DW'(1);
  assign c_inc = {1'b0, c_cur} + DW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.accept) begin
      if (c_inc >= wdt) begin
        col_q <= '0;
        row_q <= (r_inc >= hgt) ? '0 : r_inc[QW-1:0];
      end else begin
        col_q <= c_inc[QW-1:0];
        row_q <= r_cur;
      end
    end
  end

  // Pixel under work and its flags.
  logic [PW-1:0] p_q;
  logic [QW-1:0] r_q, c_q;
  logic          has_main_q, last_row_q, single_q, zero_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      p_q        <= pixel_i;
      r_q        <= r_cur;
      c_q        <= c_cur;
      has_main_q <= (r_cur != '0);
      last_row_q <= (r_inc == hgt);
      single_q   <= (r_cur == '0) && (hgt == DW'(1));
      zero_q     <= (c_inc >= wdt);
    end
  end

  // Line store: read above, then above-right, then overwrite with this pixel.
  logic [DW-1:0] c_next;
  logic [QW-1:0] raddr;
  logic [PW-1:0] rdata;

  assign c_next = {1'b0, c_q} + DW'(1);
  assign raddr  = cmd_i.rd_right ? c_next[QW-1:0] : c_q;

  pnh_ram #(
    .WIDTH (PW),
    .DEPTH (pnh_pkg::MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mul1),
    .waddr_i (c_q),
    .wdata_i (p_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Products and the weighted sum.
  logic [PW-1:0] above_q, right_q;
  logic [MW-1:0] wa_q, ww_q;
  logic [SW-1:0] wwp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_above) begin
      above_q <= rdata;
    end
    if (cmd_i.mul1) begin
      right_q <= rdata;
      wa_q    <= {{PW{1'b0}}, weight_q} * {{PW{1'b0}}, above_q};
      ww_q    <= {{PW{1'b0}}, weight_q} * {{PW{1'b0}}, weight_q};
    end
    if (cmd_i.mul2) begin
      wwp_q <= {{PW{1'b0}}, ww_q} * {{MW{1'b0}}, p_q};
    end
  end

  // Remainder by restoring division, one dividend bit per cycle.
  logic [SW-1:0] quo_q;
  logic [PW-1:0] rem_q, m_q;
  logic [NW-1:0] cnt_q;
  logic [PW:0]   part, part_sub;

  assign part     = {rem_q, quo_q[SW-1]};
  assign part_sub = part - {1'b0, m_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      quo_q <= SW'(wa_q) + wwp_q + SW'(right_q);
      rem_q <= '0;
      cnt_q <= '0;
      m_q   <= (modulus_q == '0) ? PW'(1) : modulus_q;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[SW-2:0], 1'b0};
      rem_q <= (part >= {1'b0, m_q}) ? part_sub[PW-1:0] : part[PW-1:0];
      cnt_q <= cnt_q + NW'(1);
    end
  end

  // Output register.
  logic          out_valid_q;
  logic [PW-1:0] code_q;
  logic [QW-1:0] orow_q, ocol_q;
  logic          olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_main || cmd_i.load_tail) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_main) begin
      code_q  <= zero_q ? '0 : rem_q;
      orow_q  <= r_q - QW'(1);
      ocol_q  <= c_q;
      olast_q <= !last_row_q;
    end else if (cmd_i.load_tail) begin
      code_q  <= '0;
      orow_q  <= r_q;
      ocol_q  <= c_q;
      olast_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_o        = code_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign last_of_run_o = olast_q;

  assign sts_o.div_done = (cnt_q == NW'(SW - 1));
  assign sts_o.has_main = has_main_q;
  assign sts_o.last_row = last_row_q;
  assign sts_o.single   = single_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // The remainder handed to the output is always below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_main |-> (rem_q < m_q))
    else $error("remainder not below modulus");

  // An accepted pixel always lands inside the frame it was placed in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |=> ({1'b0, c_q} < $past(wdt)) && ({1'b0, r_q} < $past(hgt)))
    else $error("pixel position outside frame");

  // A result word appears only through a load command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load_main || cmd_i.load_tail))
    else $error("output valid raised without a load");

endmodule

`default_nettype wire

// File: tb/pnh_hash_checker.sv
// Checker for the pixel neighbourhood hash block: mirrors the configuration,
// predicts the hash words of every accepted pixel word and compares them in order.
// Depends on pnh_pkg for widths, reset values and register indexes.
module pnh_hash_checker
  import pnh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             frame_start_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [PIX_W-1:0] code_i,
  input  logic [POS_W-1:0] out_row_i,
  input  logic [POS_W-1:0] out_col_i,
  input  logic             last_of_run_i,
  output int               errors_o,
  output int               words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] code;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } hash_word_t;

  hash_word_t       hash_words_due[$];
  logic [PIX_W-1:0] prev_line [MAX_WIDTH];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [PIX_W-1:0] weight;
  logic [PIX_W-1:0] modulus;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  int               mismatch_count = 0;

  assign errors_o = mismatch_count;

  // Zero counts as one, anything above the given limit saturates.
  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  task automatic queue_word(input logic [PIX_W-1:0] code, input int unsigned r,
                            input int unsigned c, input logic last);
    hash_word_t w;
    w.code = code;
    w.row  = POS_W'(r);
    w.col  = POS_W'(c);
    w.last = last;
    hash_words_due.push_back(w);
  endtask

  task automatic note_mismatch(input string field, input hash_word_t want,
                               input int unsigned got);
    int unsigned exp_val;
    case (field)
      "code":  exp_val = want.code;
      "row":   exp_val = want.row;
      "col":   exp_val = want.col;
      default: exp_val = want.last;
    endcase
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t: %s mismatch on word (%0d,%0d): expected %0d, got %0d",
               $time, field, want.row, want.col, exp_val, got);
    end
  endtask

  // One pixel word completes the pixel above it; the last row also yields
  // a zero word for the pixel's own position.
  task automatic hash_pixel(input logic [PIX_W-1:0] pix, input logic start);
    int unsigned      span;
    int unsigned      rows;
    int unsigned      divisor;
    int unsigned      r;
    int unsigned      c;
    int unsigned      sum;
    logic [PIX_W-1:0] code;
    logic             on_last_row;
    span    = clamp_dim(width_reg, MAX_WIDTH);
    rows    = clamp_dim(height_reg, MAX_HEIGHT);
    divisor = (modulus == '0) ? 1 : modulus;
    if (start || col_pos >= span || row_pos >= rows) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (r > 0) begin
      on_last_row = (r + 1 == rows);
      code = '0;
      if (c + 1 < span) begin
        sum  = weight * prev_line[c] + weight * weight * pix + prev_line[c + 1];
        code = PIX_W'(sum % divisor);
      end
      queue_word(code, r - 1, c, !on_last_row);
      if (on_last_row) queue_word('0, r, c, 1'b1);
    end else if (rows == 1) begin
      queue_word('0, r, c, 1'b1);
    end
    prev_line[c] = pix;
    if (c + 1 >= span) begin
      col_pos = 0;
      row_pos = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hash_word_t want;
    if (!rst_ni) begin
      hash_words_due.delete();
      row_pos     = 0;
      col_pos     = 0;
      weight      = BASE_WEIGHT_RST;
      modulus     = MODULUS_RST;
      width_reg   = FRAME_WIDTH_RST;
      height_reg  = FRAME_HEIGHT_RST;
      words_due_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (hash_words_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 40) begin
            $display("%0t: unexpected hash word code %0d at (%0d,%0d): expected none",
                     $time, code_i, out_row_i, out_col_i);
          end
        end else begin
          want = hash_words_due.pop_front();
          if (code_i !== want.code) note_mismatch("code", want, code_i);
          if (out_row_i !== want.row) note_mismatch("row", want, out_row_i);
          if (out_col_i !== want.col) note_mismatch("col", want, out_col_i);
          if (last_of_run_i !== want.last) note_mismatch("last", want, last_of_run_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BASE_WEIGHT:  weight     = cfg_data_i[PIX_W-1:0];
          CFG_MODULUS:      modulus    = cfg_data_i[PIX_W-1:0];
          CFG_FRAME_WIDTH:  width_reg  = cfg_data_i[DIM_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) hash_pixel(pixel_i, frame_start_i);
      words_due_o <= hash_words_due.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the pixel neighbourhood hash testbench: clock, reset, stimulus,
// result sink, watchdog and verdict. Depends on pnh_pkg, the block and pnh_hash_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pnh_pkg::*;

  // Pixel words in the random part of the run.
  localparam int PIXELS_RANDOM = 750;
  // Pixel words in each of the two oversize-dimension runs.
  localparam int PIXELS_OVERSIZE = 64;
  // Length of the one long hold-off of the result sink, in cycles.
  localparam int LONG_HOLD     = 600;
  // A row-0 pixel of a frame with more than one row yields no word but keeps
  // the block busy; this margin covers it before any register write.
  localparam int SETTLE        = 40;
  // Cycles without any handshake before the run is declared hung. The worst
  // honest quiet stretch is the long hold-off plus a sender gap plus one pixel.
  localparam int IDLE_LIMIT    = 4000;
  // Extreme values for the first frame: full scale, zero and single bits.
  localparam logic [11*PIX_W-1:0] CORNER_PIX = {
    8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd1, 8'd128
  };

  typedef enum int {
    SINK_OPEN,
    SINK_MOSTLY,
    SINK_PERIODIC,
    SINK_COIN
  } sink_mode_e;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  logic             out_valid;
  logic             out_ready;
  logic [PIX_W-1:0] code;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic             last_of_run;
  int               check_errors;
  int               words_due;

  // Sender burst bookkeeping and the hold-off request towards the sink.
  int               burst_left = 0;
  int               hold_requests = 0;
  int               holds_done = 0;
  // Effective row length as the block sees it. When a width write makes the
  // row longer, the store holds no data for the new columns yet, so the next
  // pixel word must open a fresh frame.
  int unsigned      line_span = MAX_WIDTH;
  logic             start_owed = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_neighbourhood_hash i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pixel_i       (pixel),
    .frame_start_i (frame_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .code_o        (code),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .last_of_run_o (last_of_run)
  );

  pnh_hash_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .pixel_i       (pixel),
    .frame_start_i (frame_start),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .code_i        (code),
    .out_row_i     (out_row),
    .out_col_i     (out_col),
    .last_of_run_i (last_of_run),
    .errors_o      (check_errors),
    .words_due_o   (words_due)
  );

  // Writes one register. Valid is left high so that back-to-back writes run
  // without a bubble; the caller lowers it once the setting is complete.
  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    int unsigned span;
    if (idx == CFG_FRAME_WIDTH) begin
      span = (data == '0) ? 1 : (data > MAX_WIDTH) ? MAX_WIDTH : data;
      if (span > line_span) start_owed = 1'b1;
      line_span = span;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Offers one pixel word and returns at the edge that accepts it. The sender
  // works in bursts; between most bursts it drops valid for a random gap so that
  // new words arrive at every point of the block's pixel schedule.
  // Valid is not lowered after acceptance, so a burst continues seamlessly.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    pixel       <= pix;
    frame_start <= start | start_owed;
    start_owed  = 1'b0;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering words and waits until every predicted hash word has come
  // back. The checker's count is registered, so the task first waits for the
  // last accepted pixel word to show up in it. Then the block gets time to
  // finish a pixel that yields no word before the next register write.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin : stimulus
    int               k;
    int               n;
    int               sel;
    int               phase;
    int               n_sent;
    logic [CFG_W-1:0] dim_word;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_BASE_WEIGHT;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    pixel       <= '0;
    frame_start <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full-scale weight and modulus on a 3x3 frame with extreme pixels. The
    // frame is run once and two words beyond it, so it wraps to the origin
    // and leaves the position at the last column of row 0.
    cfg_write(CFG_BASE_WEIGHT, 11'd255);
    cfg_write(CFG_MODULUS, 11'd255);
    cfg_write(CFG_FRAME_WIDTH, 11'd3);
    cfg_write(CFG_FRAME_HEIGHT, 11'd3);
    cfg_valid <= 1'b0;
    for (k = 0; k < 11; k++) send_pixel(CORNER_PIX[k*PIX_W +: PIX_W], k == 0);
    drain();

    // Weight and modulus written as zero (upper data bits set, and dropped), width
    // written as zero, a single-row frame, and a width cut below the current column:
    // the first word has no frame start yet must land at the origin.
    cfg_write(CFG_BASE_WEIGHT, 11'h700);
    cfg_write(CFG_MODULUS, 11'h500);
    cfg_write(CFG_FRAME_WIDTH, 11'd0);
    cfg_write(CFG_FRAME_HEIGHT, 11'd1);
    cfg_valid <= 1'b0;
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hFF, 1'b0);
    drain();

    // A 2x2 frame with the modulus still at zero, so every hash is zero, and
    // a frame start on the word that opens the next frame anyway.
    cfg_write(CFG_BASE_WEIGHT, 11'd16);
    cfg_write(CFG_FRAME_WIDTH, 11'd2);
    cfg_write(CFG_FRAME_HEIGHT, 11'd2);
    cfg_valid <= 1'b0;
    for (k = 0; k < 6; k++) send_pixel(PIX_W'($urandom), k == 4);
    drain();

    // Width above the maximum saturates to the full line store. With a single
    // row every word returns a zero for its own column, and the row does not
    // break where a narrower frame would.
    cfg_write(CFG_BASE_WEIGHT, CFG_W'($urandom));
    cfg_write(CFG_MODULUS, CFG_W'($urandom));
    cfg_write(CFG_FRAME_WIDTH, 11'h7FF);
    cfg_write(CFG_FRAME_HEIGHT, 11'd1);
    cfg_valid <= 1'b0;
    for (k = 0; k < PIXELS_OVERSIZE; k++) send_pixel(PIX_W'($urandom), 1'b0);
    drain();

    // The same for the height: a one-pixel-wide column taller than the
    // maximum walks down the row field, each later word closing the pixel above.
    cfg_write(CFG_FRAME_WIDTH, 11'd1);
    cfg_write(CFG_FRAME_HEIGHT, 11'h7FF);
    cfg_valid <= 1'b0;
    for (k = 0; k < PIXELS_OVERSIZE; k++) send_pixel(PIX_W'($urandom), k == 0);
    drain();

    // Random part: short phases, each with a random new setting and a run of
    // pixel words over small frames, so most words complete a hash and the
    // frames wrap often. A phase's first word carries a frame start half the time;
    // a rare one later in the phase breaks a frame. Now and then the dimensions are zero or
    // beyond the maximum, and a shrinking setting may leave the position
    // outside the frame. The first phase writes everything and asks the sink
    // for its long hold-off while words keep coming, so the block backs up.
    n_sent = 0;
    phase  = 0;
    while (n_sent < PIXELS_RANDOM) begin
      if (phase == 0 || $urandom_range(0, 1) != 0) begin
        cfg_write(CFG_BASE_WEIGHT, CFG_W'($urandom));
      end
      if (phase == 0 || $urandom_range(0, 1) != 0) begin
        cfg_write(CFG_MODULUS, CFG_W'($urandom));
      end
      if (phase == 0 || $urandom_range(0, 1) != 0) begin
        sel = $urandom_range(0, 15);
        if (phase == 0 || sel < 11) begin
          dim_word = $urandom_range(1, 8);
        end else if (sel < 13) begin
          dim_word = '0;
        end else if (sel < 15) begin
          dim_word = $urandom_range(9, 40);
        end else begin
          dim_word = $urandom_range(MAX_WIDTH + 1, 2047);
        end
        cfg_write(CFG_FRAME_WIDTH, dim_word);
      end
      if (phase == 0 || $urandom_range(0, 1) != 0) begin
        sel = $urandom_range(0, 15);
        if (phase == 0 || sel < 12) begin
          dim_word = $urandom_range(1, 6);
        end else if (sel < 14) begin
          dim_word = '0;
        end else begin
          dim_word = $urandom_range(MAX_HEIGHT + 1, 2047);
        end
        cfg_write(CFG_FRAME_HEIGHT, dim_word);
      end
      cfg_valid <= 1'b0;

      n = $urandom_range(16, 64);
      for (k = 0; k < n; k++) begin
        if (phase == 0 && k == 3) hold_requests++;
        sel = $urandom_range(0, 15);
        send_pixel((sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : PIX_W'($urandom),
                   (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0));
      end
      n_sent += n;
      phase++;
      drain();
    end

    if (check_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result sink. It runs stretches of random length, each with its own stall
  // pattern: always ready, mostly ready, ready once per period, or a coin
  // toss. When the stimulus asks for it, it holds ready low for the long
  // hold-off, whose length it counts itself.
  initial begin : result_sink
    int         stretch;
    int         period;
    int         k;
    sink_mode_e mode;
    out_ready <= 1'b0;
    forever begin
      if (hold_requests != holds_done) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end
      stretch = $urandom_range(8, 200);
      mode    = sink_mode_e'($urandom_range(0, 3));
      period  = $urandom_range(2, 9);
      for (k = 0; k < stretch && hold_requests == holds_done; k++) begin
        @(posedge clk);
        case (mode)
          SINK_OPEN:     out_ready <= 1'b1;
          SINK_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
          SINK_PERIODIC: out_ready <= (k % period == 0);
          default:       out_ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // Watchdog: any handshake on any channel, or reset, restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pnh_pkg.sv
rtl/pnh_ram.sv
rtl/pnh_ctrl.sv
rtl/pnh_datapath.sv
rtl/pixel_neighbourhood_hash.sv
tb/pnh_hash_checker.sv
tb/testbench.sv
